>>> rtl/psq_pkg.sv
// ----------------------------------------------------------------------------
// psq_pkg
// Shared types and constants for the priority scheduler with sleep queue.
// ----------------------------------------------------------------------------
package psq_pkg;

  localparam int unsigned MAX_TASKS = 16;
  localparam int unsigned IDX_W     = $clog2(MAX_TASKS);
  localparam int unsigned LEN_W     = $clog2(MAX_TASKS + 1);
  localparam int unsigned ID_W      = 4;
  localparam int unsigned PRIO_W    = 6;
  localparam int unsigned WAKE_W    = 63;

  localparam logic [PRIO_W-1:0] PRIO_DEFAULT  = PRIO_W'(31);
  localparam logic [7:0]        SLICE_DEFAULT = 8'd4;
  localparam logic [7:0]        SLICE_MAX     = 8'd255;

  typedef enum logic [2:0] {
    REQ_UNBLOCK = 3'd0,
    REQ_YIELD   = 3'd1,
    REQ_BLOCK   = 3'd2,
    REQ_SLEEP   = 3'd3,
    REQ_TICK    = 3'd4,
    REQ_SETPRIO = 3'd5
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_IDLE = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] priority_req;
    logic [WAKE_W-1:0] tick_value;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]   running_id;
    logic              running_is_idle;
    logic [PRIO_W-1:0] running_priority;
    logic              yield_request;
    logic [4:0]        ready_count;
    logic [4:0]        sleep_count;
    logic [1:0]        status;
  } rsp_t;

  // ready queue entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } rq_ent_t;

  // sleep queue entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [WAKE_W-1:0] wake;
  } sq_ent_t;

endpackage

>>> rtl/psq_ram.sv
// ----------------------------------------------------------------------------
// psq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module psq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/priority_scheduler_with_sleep_queue.sv
// ----------------------------------------------------------------------------
// priority_scheduler_with_sleep_queue
// Preemptive priority scheduler: running task, ready queue sorted by
// descending priority, sleep queue sorted by ascending wake time.
// ----------------------------------------------------------------------------
//
//   channel | signals                         | direction | notes
//   --------+---------------------------------+-----------+-------------------
//   req     | req_valid_i/req_ready_o/req_i   | in        | one request
//   rsp     | rsp_valid_o/rsp_ready_i/rsp_o   | out       | one result per req
//   cfg     | cfg_we_i/cfg_data_i             | in        | slice length, no wait
//
// One request at a time: accept, one decode state per phase, then the result
// holds until taken. Queue walks move one entry at a time through a RAM read
// state and then a write-back state; each insert or pop walk is followed by
// a decode state. A tick adds one insert and one pop per woken sleeper.
// Reset is immediate; queue RAMs are not cleared (only entries below the
// length are read). A result held by rsp_ready_i low blocks the next request.
// ----------------------------------------------------------------------------
module priority_scheduler_with_sleep_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  psq_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output psq_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_data_i
);

  // sequencer states
  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_DEC   = 11'b000_0000_0010,
    S_RI_RD = 11'b000_0000_0100,
    S_RI_WR = 11'b000_0000_1000,
    S_RP_RD = 11'b000_0001_0000,
    S_RP_WR = 11'b000_0010_0000,
    S_SI_RD = 11'b000_0100_0000,
    S_SI_WR = 11'b000_1000_0000,
    S_SP_RD = 11'b001_0000_0000,
    S_SP_WR = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_e;

  // what the decode state does next for the current request
  typedef enum logic [6:0] {
    PH_START   = 7'b000_0001,
    PH_PREEMPT = 7'b000_0010,
    PH_REINS   = 7'b000_0100,
    PH_DONE    = 7'b000_1000,
    PH_LEAVE   = 7'b001_0000,
    PH_TLOOP   = 7'b010_0000,
    PH_TPOP    = 7'b100_0000
  } phase_e;

  localparam int unsigned LW = psq_pkg::LEN_W;
  localparam int unsigned IW = psq_pkg::IDX_W;
  localparam logic [LW-1:0] LEN_FULL = LW'(psq_pkg::MAX_TASKS);

  state_e state_q, state_d;
  phase_e ph_q, ph_d;

  psq_pkg::req_t    req_q, req_d;
  logic [LW-1:0]    rlen_q, rlen_d, slen_q, slen_d;
  logic [LW-1:0]    k_q, k_d;
  logic [psq_pkg::ID_W-1:0]   cur_id_q, cur_id_d;
  logic [psq_pkg::PRIO_W-1:0] cur_prio_q, cur_prio_d;
  logic             idle_q, idle_d;
  logic [7:0]       slice_q, slice_d, tslice_q;
  logic             expired_q, expired_d;
  logic             yreq_q, yreq_d;
  logic [1:0]       status_q, status_d;
  psq_pkg::rq_ent_t rfront_q, rfront_d, old_q, old_d;
  psq_pkg::sq_ent_t sfront_q, sfront_d, ins_q, ins_d;

  // RAM ports
  logic             r_we, s_we;
  logic [IW-1:0]    r_waddr, s_waddr, raddr;
  psq_pkg::rq_ent_t r_wdata, r_rdata;
  psq_pkg::sq_ent_t s_wdata, s_rdata;
  psq_pkg::rq_ent_t ins_r;
  logic [7:0]       slice_inc;

  assign ins_r = '{id: ins_q.id, prio: ins_q.prio};
  assign slice_inc = (slice_q == psq_pkg::SLICE_MAX) ? slice_q : slice_q + 8'd1;

  // shift walks read one slot ahead: insert walks down, pop walks up
  assign raddr = (state_q == S_RP_RD || state_q == S_SP_RD) ? IW'(k_q + LW'(1))
                                                            : IW'(k_q - LW'(1));

  psq_ram #(.Width($bits(psq_pkg::rq_ent_t)), .Depth(psq_pkg::MAX_TASKS)) u_rq_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (raddr),
    .rdata_o (r_rdata)
  );

  psq_ram #(.Width($bits(psq_pkg::sq_ent_t)), .Depth(psq_pkg::MAX_TASKS)) u_sq_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (raddr),
    .rdata_o (s_rdata)
  );

  always_comb begin
    state_d   = state_q;
    ph_d      = ph_q;
    req_d     = req_q;
    rlen_d    = rlen_q;
    slen_d    = slen_q;
    k_d       = k_q;
    cur_id_d  = cur_id_q;
    cur_prio_d = cur_prio_q;
    idle_d    = idle_q;
    slice_d   = slice_q;
    expired_d = expired_q;
    yreq_d    = yreq_q;
    status_d  = status_q;
    rfront_d  = rfront_q;
    sfront_d  = sfront_q;
    old_d     = old_q;
    ins_d     = ins_q;
    r_we      = 1'b0;
    r_waddr   = IW'(k_q);
    r_wdata   = ins_r;
    s_we      = 1'b0;
    s_waddr   = IW'(k_q);
    s_wdata   = ins_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d    = req_i;
          ph_d     = PH_START;
          yreq_d   = 1'b0;
          status_d = psq_pkg::ST_OK;
          state_d  = S_DEC;
        end
      end

      S_DEC: begin
        state_d = S_OUT;
        unique case (ph_q)
          PH_START: begin
            unique case (req_q.req_type)
              psq_pkg::REQ_UNBLOCK: begin
                if (idle_q) begin
                  cur_id_d   = req_q.task_id;
                  cur_prio_d = req_q.priority_req;
                  idle_d     = 1'b0;
                  slice_d    = '0;
                end else if (rlen_q == LEN_FULL) begin
                  status_d = psq_pkg::ST_FULL;
                end else begin
                  ins_d   = '{id: req_q.task_id, prio: req_q.priority_req, wake: '0};
                  k_d     = rlen_q;
                  ph_d    = PH_PREEMPT;
                  state_d = S_RI_RD;
                end
              end
              psq_pkg::REQ_YIELD: begin
                slice_d = '0;
                if (!idle_q && rlen_q != '0 && rfront_q.prio >= cur_prio_q) begin
                  old_d      = '{id: cur_id_q, prio: cur_prio_q};
                  cur_id_d   = rfront_q.id;
                  cur_prio_d = rfront_q.prio;
                  k_d        = '0;
                  ph_d       = PH_REINS;
                  state_d    = S_RP_RD;
                end
              end
              psq_pkg::REQ_BLOCK: begin
                if (idle_q) begin
                  status_d = psq_pkg::ST_IDLE;
                end else begin
                  ph_d    = PH_LEAVE;
                  state_d = S_DEC;
                end
              end
              psq_pkg::REQ_SLEEP: begin
                if (idle_q) begin
                  status_d = psq_pkg::ST_IDLE;
                end else if (slen_q == LEN_FULL) begin
                  status_d = psq_pkg::ST_FULL;
                end else begin
                  ins_d   = '{id: cur_id_q, prio: cur_prio_q, wake: req_q.tick_value};
                  k_d     = slen_q;
                  ph_d    = PH_LEAVE;
                  state_d = S_SI_RD;
                end
              end
              psq_pkg::REQ_TICK: begin
                slice_d   = slice_inc;
                expired_d = (slice_inc >= tslice_q);
                ph_d      = PH_TLOOP;
                state_d   = S_DEC;
              end
              psq_pkg::REQ_SETPRIO: begin
                if (!idle_q) begin
                  cur_prio_d = req_q.priority_req;
                  ph_d       = PH_PREEMPT;
                  state_d    = S_DEC;
                end
              end
              default: begin
              end
            endcase
          end
          PH_PREEMPT: begin
            if (!idle_q && rlen_q != '0 && rfront_q.prio > cur_prio_q) begin
              slice_d    = '0;
              old_d      = '{id: cur_id_q, prio: cur_prio_q};
              cur_id_d   = rfront_q.id;
              cur_prio_d = rfront_q.prio;
              k_d        = '0;
              ph_d       = PH_REINS;
              state_d    = S_RP_RD;
            end
          end
          PH_REINS: begin
            // pop just freed a slot, so this cannot overflow
            ins_d   = '{id: old_q.id, prio: old_q.prio, wake: '0};
            k_d     = rlen_q;
            ph_d    = PH_DONE;
            state_d = S_RI_RD;
          end
          PH_DONE: begin
          end
          PH_LEAVE: begin
            slice_d = '0;
            if (rlen_q != '0) begin
              cur_id_d   = rfront_q.id;
              cur_prio_d = rfront_q.prio;
              idle_d     = 1'b0;
              k_d        = '0;
              ph_d       = PH_DONE;
              state_d    = S_RP_RD;
            end else begin
              idle_d = 1'b1;
            end
          end
          PH_TLOOP: begin
            if (slen_q != '0 && sfront_q.wake <= req_q.tick_value &&
                rlen_q != LEN_FULL) begin
              ins_d   = sfront_q;
              k_d     = rlen_q;
              ph_d    = PH_TPOP;
              state_d = S_RI_RD;
            end else begin
              if (slen_q != '0 && sfront_q.wake <= req_q.tick_value) begin
                status_d = psq_pkg::ST_FULL;
              end
              if (idle_q) begin
                if (rlen_q != '0) begin
                  cur_id_d   = rfront_q.id;
                  cur_prio_d = rfront_q.prio;
                  idle_d     = 1'b0;
                  slice_d    = '0;
                  k_d        = '0;
                  ph_d       = PH_DONE;
                  state_d    = S_RP_RD;
                end
              end else begin
                yreq_d = expired_q || (rlen_q != '0 && rfront_q.prio > cur_prio_q);
              end
            end
          end
          PH_TPOP: begin
            k_d     = '0;
            ph_d    = PH_TLOOP;
            state_d = S_SP_RD;
          end
          default: begin
          end
        endcase
      end

      // ready insert: walk down from the tail, shifting lower priorities up
      S_RI_RD: begin
        if (k_q == '0) begin
          r_we     = 1'b1;
          rfront_d = ins_r;
          rlen_d   = rlen_q + LW'(1);
          state_d  = S_DEC;
        end else begin
          state_d = S_RI_WR;
        end
      end
      S_RI_WR: begin
        r_we = 1'b1;
        if (r_rdata.prio >= ins_q.prio) begin
          rlen_d  = rlen_q + LW'(1);
          state_d = S_DEC;
        end else begin
          r_wdata = r_rdata;
          k_d     = k_q - LW'(1);
          state_d = S_RI_RD;
        end
      end

      // ready pop: shift every entry one slot toward the front
      S_RP_RD: begin
        if (k_q + LW'(1) >= rlen_q) begin
          rlen_d  = rlen_q - LW'(1);
          state_d = S_DEC;
        end else begin
          state_d = S_RP_WR;
        end
      end
      S_RP_WR: begin
        r_we    = 1'b1;
        r_wdata = r_rdata;
        if (k_q == '0) begin
          rfront_d = r_rdata;
        end
        k_d     = k_q + LW'(1);
        state_d = S_RP_RD;
      end

      // sleep insert: equal wake times stay first-in first-out
      S_SI_RD: begin
        if (k_q == '0) begin
          s_we     = 1'b1;
          sfront_d = ins_q;
          slen_d   = slen_q + LW'(1);
          state_d  = S_DEC;
        end else begin
          state_d = S_SI_WR;
        end
      end
      S_SI_WR: begin
        s_we = 1'b1;
        if (s_rdata.wake <= ins_q.wake) begin
          slen_d  = slen_q + LW'(1);
          state_d = S_DEC;
        end else begin
          s_wdata = s_rdata;
          k_d     = k_q - LW'(1);
          state_d = S_SI_RD;
        end
      end

      // sleep pop: shift every entry one slot toward the front
      S_SP_RD: begin
        if (k_q + LW'(1) >= slen_q) begin
          slen_d  = slen_q - LW'(1);
          state_d = S_DEC;
        end else begin
          state_d = S_SP_WR;
        end
      end
      S_SP_WR: begin
        s_we    = 1'b1;
        s_wdata = s_rdata;
        if (k_q == '0) begin
          sfront_d = s_rdata;
        end
        k_d     = k_q + LW'(1);
        state_d = S_SP_RD;
      end

      S_OUT: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ph_q       <= PH_START;
      rlen_q     <= '0;
      slen_q     <= '0;
      k_q        <= '0;
      cur_id_q   <= '0;
      cur_prio_q <= psq_pkg::PRIO_DEFAULT;
      idle_q     <= 1'b0;
      slice_q    <= '0;
      tslice_q   <= psq_pkg::SLICE_DEFAULT;
      expired_q  <= 1'b0;
      yreq_q     <= 1'b0;
      status_q   <= psq_pkg::ST_OK;
    end else begin
      state_q    <= state_d;
      ph_q       <= ph_d;
      rlen_q     <= rlen_d;
      slen_q     <= slen_d;
      k_q        <= k_d;
      cur_id_q   <= cur_id_d;
      cur_prio_q <= cur_prio_d;
      idle_q     <= idle_d;
      slice_q    <= slice_d;
      expired_q  <= expired_d;
      yreq_q     <= yreq_d;
      status_q   <= status_d;
      if (cfg_we_i) begin
        tslice_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    rfront_q <= rfront_d;
    sfront_q <= sfront_d;
    old_q    <= old_d;
    ins_q    <= ins_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_OUT);

  always_comb begin
    rsp_o.running_id       = idle_q ? '0 : cur_id_q;
    rsp_o.running_is_idle  = idle_q;
    rsp_o.running_priority = idle_q ? '0 : cur_prio_q;
    rsp_o.yield_request    = yreq_q;
    rsp_o.ready_count      = 5'(rlen_q);
    rsp_o.sleep_count      = 5'(slen_q);
    rsp_o.status           = status_q;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rlen_q <= LEN_FULL && slen_q <= LEN_FULL)
    else $error("queue length beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RP_RD |-> rlen_q != '0)
    else $error("ready pop on empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RI_RD |-> k_q <= rlen_q && rlen_q != LEN_FULL)
    else $error("ready insert walk out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SI_RD |-> k_q <= slen_q && slen_q != LEN_FULL)
    else $error("sleep insert walk out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SP_RD |-> slen_q != '0)
    else $error("sleep pop on empty queue");

endmodule
